### src/ctte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctte_pkg
// shared constants and helpers for the civil time to unix seconds converter
// ----------------------------------------------------------------------------
package ctte_pkg;

  localparam int unsigned InWidth   = 48;
  localparam int unsigned OutWidth  = 40;
  localparam int unsigned DaysWidth = 17;
  localparam int unsigned TodWidth  = 19;

  // day count from 1970-01-01 to 1999-03-01
  localparam logic [DaysWidth-1:0] BaseDays     = 17'd10651;
  localparam logic [16:0]          SecPerDay    = 17'd86400;
  localparam logic [31:0]          MinEpochInit = 32'd1700000000;

  // days from march 1 to the first of the given month
  function automatic logic [8:0] month_start(input logic [3:0] month);
    logic [8:0] doy;
    case (month)
      4'd3:    doy = 9'd0;
      4'd4:    doy = 9'd31;
      4'd5:    doy = 9'd61;
      4'd6:    doy = 9'd92;
      4'd7:    doy = 9'd122;
      4'd8:    doy = 9'd153;
      4'd9:    doy = 9'd184;
      4'd10:   doy = 9'd214;
      4'd11:   doy = 9'd245;
      4'd12:   doy = 9'd275;
      4'd1:    doy = 9'd306;
      4'd2:    doy = 9'd337;
      default: doy = 9'd0;
    endcase
    return doy;
  endfunction

endpackage

### src/civil_time_to_epoch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// civil_time_to_epoch
// converts a parsed clock reading (20yy, month, day, time, zone) to unix seconds
// ----------------------------------------------------------------------------
//
// channel   direction  handshake            content
// s_*       in         s_tvalid / s_tready  one clock reading per request
// m_*       out        m_tvalid / m_tready  epoch seconds and valid flag
// cfg_*     in         cfg_valid/cfg_ready  min_valid_epoch write
//
// four register stages: field check and day count, days times 86400,
// add of time of day and zone, compare against the minimum and output.
// one request per cycle sustained while m_tready stays high.
// each stage holds while the stage after it is full and stalled, so bubbles
// close up and nothing is dropped or repeated; the multiply sets the depth.
// rst clears stage valids and loads min_valid_epoch with 1700000000.
// cfg_ready is always high.

module civil_time_to_epoch (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // year_two_digit[6:0], month_num[10:7], day_num[15:11], hour_num[20:16],
  // minute_num[26:21], second_num[32:27], tz_present[33], tz_negative[34],
  // tz_quarter_hours[41:35], zero fill
  input  logic [ctte_pkg::InWidth-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // epoch_seconds[31:0], valid_res[32], zero fill
  output logic [ctte_pkg::OutWidth-1:0] m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [31:0]                   cfg_data
);

  // input field split
  logic [6:0] year_two_digit;
  logic [3:0] month_num;
  logic [4:0] day_num;
  logic [4:0] hour_num;
  logic [5:0] minute_num;
  logic [5:0] second_num;
  logic       tz_present;
  logic       tz_negative;
  logic [6:0] tz_quarter_hours;

  assign year_two_digit   = s_tdata[6:0];
  assign month_num        = s_tdata[10:7];
  assign day_num          = s_tdata[15:11];
  assign hour_num         = s_tdata[20:16];
  assign minute_num       = s_tdata[26:21];
  assign second_num       = s_tdata[32:27];
  assign tz_present       = s_tdata[33];
  assign tz_negative      = s_tdata[34];
  assign tz_quarter_hours = s_tdata[41:35];

  // configuration register
  logic [31:0] min_valid_epoch;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_valid_epoch <= ctte_pkg::MinEpochInit;
    end else if (cfg_valid && cfg_ready) begin
      min_valid_epoch <= cfg_data;
    end
  end

  // stage advance: a stage loads when it is empty or its contents move on
  logic adv1, adv2, adv3, adv4;
  logic v1, v2, v3;
  logic ok1, ok2, ok3;

  assign adv4     = !m_tvalid || m_tready;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign s_tready = adv1;

  // stage 1 logic: range check, march-based day count, time of day minus zone
  logic                                 fields_ok;
  logic [7:0]                           year_idx;   // march years since 1999
  logic [ctte_pkg::DaysWidth-1:0]       days_next;
  logic signed [ctte_pkg::TodWidth-1:0] tod_next;
  logic [16:0]                          hour_sec;
  logic [11:0]                          min_sec;
  logic [16:0]                          zone_sec;

  assign fields_ok = (year_two_digit <= 7'd99) && (month_num >= 4'd1) &&
                     (month_num <= 4'd12) && (day_num != 5'd0) &&
                     (hour_num <= 5'd23) && (minute_num <= 6'd59) &&
                     (second_num <= 6'd60);

  // january and february belong to the previous march-based year
  assign year_idx = {1'b0, year_two_digit} + 8'd1 - {7'd0, (month_num <= 4'd2)};

  // leap days passed: every fourth march year starting with the first
  assign days_next = ctte_pkg::BaseDays
                   + 17'(year_idx) * 17'd365
                   + 17'(year_idx + 8'd3 >> 2)
                   + 17'(ctte_pkg::month_start(month_num))
                   + 17'(day_num) - 17'd1;

  assign hour_sec = 17'(hour_num) * 17'd3600;
  assign min_sec  = 12'(minute_num) * 12'd60;
  assign zone_sec = tz_present ? 17'(tz_quarter_hours) * 17'd900 : 17'd0;

  // a minus zone adds seconds
  assign tod_next = tz_negative
                  ? $signed({2'b00, hour_sec}) + $signed(19'(min_sec))
                    + $signed(19'(second_num)) + $signed({2'b00, zone_sec})
                  : $signed({2'b00, hour_sec}) + $signed(19'(min_sec))
                    + $signed(19'(second_num)) - $signed({2'b00, zone_sec});

  logic [ctte_pkg::DaysWidth-1:0]       days1;
  logic signed [ctte_pkg::TodWidth-1:0] tod1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      ok1   <= fields_ok;
      days1 <= days_next;
      tod1  <= tod_next;
    end
  end

  // stage 2: day count to seconds
  logic [33:0]                          prod_full;
  logic [31:0]                          prod2;
  logic signed [ctte_pkg::TodWidth-1:0] tod2;

  assign prod_full = days1 * ctte_pkg::SecPerDay;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      ok2   <= ok1;
      prod2 <= prod_full[31:0];
      tod2  <= tod1;
    end
  end

  // stage 3: utc seconds; accepted readings always land inside 32 bits
  logic [31:0] utc3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      ok3  <= ok2;
      utc3 <= prod2 + 32'($signed(tod2));
    end
  end

  // stage 4: minimum check and output register
  logic        pass;
  logic [31:0] epoch_seconds;
  logic        valid_res;

  assign pass = ok3 && (utc3 >= min_valid_epoch);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv4) begin
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      valid_res     <= pass;
      epoch_seconds <= pass ? utc3 : 32'd0;
    end
  end

  assign m_tdata = {7'd0, valid_res, epoch_seconds};

  // checks
  a_valid_above_min: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[32] |-> m_tdata[31:0] >= min_valid_epoch)
    else $error("valid result below minimum epoch");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[32] |-> m_tdata[31:0] == 32'd0)
    else $error("rejected result carries nonzero epoch");

  a_bad_fields_rejected: assert property (@(posedge clk) disable iff (rst)
    v3 && !ok3 && adv4 |=> m_tvalid && !m_tdata[32])
    else $error("out of range reading marked valid");

endmodule

### verif/tb_civil_time_to_epoch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_civil_time_to_epoch
// self-checking bench for the clock reading to unix seconds converter: a
// directed pass over field limits, zone handling and the minimum epoch, then
// random readings under several minimum settings with random stalls on both
// streams; every result is compared with an in-bench conversion in order
// ----------------------------------------------------------------------------

module tb_civil_time_to_epoch;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned DrainCycles  = 12;     // pipeline is four deep
  localparam int unsigned PhaseItems   = 220;
  localparam int unsigned MaxReported  = 10;

  // one parsed clock reading, laid out as on s_tdata (last field lowest)
  typedef struct packed {
    logic [6:0] tz_quarter_hours;
    logic       tz_negative;
    logic       tz_present;
    logic [5:0] second_num;
    logic [5:0] minute_num;
    logic [4:0] hour_num;
    logic [4:0] day_num;
    logic [3:0] month_num;
    logic [6:0] year_two_digit;
  } reading_t;

  typedef struct {
    logic [31:0] epoch_seconds;
    logic        valid_res;
  } conversion_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  // year_two_digit, month_num, day_num, hour_num, minute_num, second_num,
  // tz_present, tz_negative, tz_quarter_hours, zero fill
  logic [ctte_pkg::InWidth-1:0]      s_tdata = '0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  // epoch_seconds, valid_res, zero fill
  logic [ctte_pkg::OutWidth-1:0]     m_tdata;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [31:0]                       cfg_data = '0;

  // bench copy of the minimum epoch register
  logic [31:0]  min_epoch_model = ctte_pkg::MinEpochInit;
  conversion_t  expected_conversions[$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  bit           tx_idle_on = 1'b1;
  bit           rx_idle_on = 1'b1;

  civil_time_to_epoch dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // expected conversion of one reading under the current minimum
  // ---------------------------------------------------------------------------
  function automatic conversion_t convert_reading(reading_t r);
    conversion_t res;
    longint yr, era, yoe, march_month, doy, doe, days, zone, utc;
    res.epoch_seconds = '0;
    res.valid_res = 1'b0;
    // any field out of range rejects the whole reading
    if (r.year_two_digit > 99 || r.month_num == 0 || r.month_num > 12 ||
        r.day_num == 0 || r.hour_num > 23 || r.minute_num > 59 ||
        r.second_num > 60)
      return res;
    // years start in march so the leap day lands at the end
    yr = 2000 + longint'(r.year_two_digit) - (r.month_num <= 2 ? 1 : 0);
    era = yr / 400;
    yoe = yr - era * 400;
    march_month = (r.month_num > 2) ? longint'(r.month_num) - 3
                                    : longint'(r.month_num) + 9;
    // day is not checked against month length, it just runs on
    doy = (153 * march_month + 2) / 5 + longint'(r.day_num) - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * 146097 + doe - 719468;
    // zone flags only count when a zone was given
    zone = 0;
    if (r.tz_present) begin
      zone = longint'(r.tz_quarter_hours) * 900;
      if (r.tz_negative)
        zone = -zone;
    end
    utc = days * 86400 + longint'(r.hour_num) * 3600 +
          longint'(r.minute_num) * 60 + longint'(r.second_num) - zone;
    if (utc < longint'(min_epoch_model) || utc > 64'sh0_FFFF_FFFF)
      return res;
    res.epoch_seconds = utc[31:0];
    res.valid_res = 1'b1;
    return res;
  endfunction

  function automatic reading_t make_reading(int yy, int mo, int dd, int hh, int mi,
                                            int ss, bit tzp, bit tzn, int tzq);
    reading_t r;
    r.year_two_digit   = yy[6:0];
    r.month_num        = mo[3:0];
    r.day_num          = dd[4:0];
    r.hour_num         = hh[4:0];
    r.minute_num       = mi[5:0];
    r.second_num       = ss[5:0];
    r.tz_present       = tzp;
    r.tz_negative      = tzn;
    r.tz_quarter_hours = tzq[6:0];
    return r;
  endfunction

  // random reading: mostly in range, some with one field broken, some noise
  function automatic reading_t random_reading();
    reading_t r;
    int pick;
    r = make_reading($urandom_range(0, 99), $urandom_range(1, 12),
                     $urandom_range(1, 31), $urandom_range(0, 23),
                     $urandom_range(0, 59), $urandom_range(0, 60),
                     $urandom_range(0, 1), $urandom_range(0, 1),
                     $urandom_range(0, 127));
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      r = reading_t'({$urandom, $urandom});
    end else if (pick < 22) begin
      case ($urandom_range(0, 5))
        0:       r.year_two_digit = 7'($urandom_range(100, 127));
        1:       r.month_num = ($urandom_range(0, 1) != 0) ? 4'd0
                                                          : 4'($urandom_range(13, 15));
        2:       r.day_num = 5'd0;
        3:       r.hour_num = 5'($urandom_range(24, 31));
        4:       r.minute_num = 6'($urandom_range(60, 63));
        default: r.second_num = 6'($urandom_range(61, 63));
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stream drivers
  // ---------------------------------------------------------------------------

  // valid stays high across back-to-back requests, lowered only for a gap
  task automatic send_reading(reading_t r);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    expected_conversions.push_back(convert_reading(r));
    s_tvalid <= 1'b1;
    s_tdata  <= {{(ctte_pkg::InWidth - $bits(reading_t)){1'b0}}, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // sender holds off until every outstanding result is back
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (expected_conversions.size() != 0) @(posedge clk);
  endtask

  // only called with the pipeline empty
  task automatic write_min_epoch(logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    min_epoch_model = value;
  endtask

  // result side backpressure, drawn fresh for every result
  initial begin : result_sink
    int stall;
    @(negedge rst);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // in-order compare of every accepted result against the oldest expectation
  always @(posedge clk) begin : result_check
    conversion_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_conversions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReported)
          $display("unexpected result: epoch %0d valid %0b",
                   m_tdata[31:0], m_tdata[32]);
      end else begin
        want = expected_conversions.pop_front();
        if (m_tdata[31:0] !== want.epoch_seconds || m_tdata[32] !== want.valid_res) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported)
            $display("mismatch: expected epoch %0d valid %0b, got epoch %0d valid %0b",
                     want.epoch_seconds, want.valid_res, m_tdata[31:0], m_tdata[32]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset value of the minimum: 2023-11-14 22:13:20 utc is exactly 1700000000
  task automatic test_reset_minimum();
    send_reading(make_reading(23, 11, 14, 22, 13, 20, 0, 0, 0));
    send_reading(make_reading(23, 11, 14, 22, 13, 19, 0, 0, 0));
    // same instant expressed in a plus one hour zone
    send_reading(make_reading(23, 11, 14, 23, 13, 20, 1, 0, 4));
    wait_for_results();
  endtask

  // field extremes, zone handling and unchecked month lengths, minimum at zero
  task automatic test_field_limits();
    write_min_epoch(32'd0);
    send_reading(make_reading(0, 1, 1, 0, 0, 0, 0, 0, 0));        // earliest year
    send_reading(make_reading(99, 12, 31, 23, 59, 60, 0, 0, 0));  // latest, leap second
    send_reading(make_reading(100, 6, 15, 12, 0, 0, 0, 0, 0));
    send_reading(make_reading(127, 12, 31, 23, 59, 59, 0, 0, 0));
    send_reading(make_reading(20, 0, 10, 0, 0, 0, 0, 0, 0));
    send_reading(make_reading(20, 13, 10, 0, 0, 0, 0, 0, 0));
    send_reading(make_reading(20, 15, 10, 0, 0, 0, 0, 0, 0));
    send_reading(make_reading(20, 5, 0, 0, 0, 0, 0, 0, 0));
    send_reading(make_reading(20, 5, 31, 24, 0, 0, 0, 0, 0));
    send_reading(make_reading(20, 5, 31, 31, 0, 0, 0, 0, 0));
    send_reading(make_reading(20, 5, 31, 10, 60, 0, 0, 0, 0));
    send_reading(make_reading(20, 5, 31, 10, 63, 0, 0, 0, 0));
    send_reading(make_reading(20, 5, 31, 10, 30, 61, 0, 0, 0));
    send_reading(make_reading(20, 5, 31, 10, 30, 63, 0, 0, 0));
    // widest zones at both ends of the range
    send_reading(make_reading(0, 1, 1, 0, 0, 0, 1, 0, 127));
    send_reading(make_reading(99, 12, 31, 23, 59, 60, 1, 1, 127));
    // zone flags set but no zone given
    send_reading(make_reading(50, 7, 4, 8, 15, 30, 0, 1, 127));
    // minus zero offset
    send_reading(make_reading(50, 7, 4, 8, 15, 30, 1, 1, 0));
    // february 31 in a common year and leap days
    send_reading(make_reading(23, 2, 31, 0, 0, 0, 0, 0, 0));
    send_reading(make_reading(0, 2, 29, 12, 0, 0, 0, 0, 0));
    send_reading(make_reading(24, 2, 30, 12, 0, 0, 0, 0, 0));
    send_reading(make_reading(0, 2, 28, 23, 59, 59, 1, 0, 1));
    wait_for_results();
  endtask

  // random readings under a series of minimum settings, extremes included
  task automatic test_random_traffic();
    logic [31:0] floors[5];
    int unsigned mode;
    floors[0] = 32'hFFFF_FFFF;
    floors[1] = ctte_pkg::MinEpochInit;
    floors[2] = $urandom_range(32'd946570500, 32'd4102559100);
    floors[3] = $urandom_range(32'd946570500, 32'd4102559100);
    floors[4] = 32'd0;
    foreach (floors[p]) begin
      write_min_epoch(floors[p]);
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        // re-draw idling every 40 requests; mode zero runs with no gaps at all
        if (n % 40 == 0) begin
          mode = $urandom_range(0, 3);
          tx_idle_on = mode[0];
          rx_idle_on = mode[1];
        end
        send_reading(random_reading());
      end
      wait_for_results();
    end
  endtask

  initial begin : main_sequence
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_minimum();
    test_field_limits();
    test_random_traffic();
    wait_for_results();
    repeat (DrainCycles) @(posedge clk);
    if (expected_conversions.size() != 0) begin
      mismatch_count += expected_conversions.size();
      $display("%0d results never arrived", expected_conversions.size());
    end
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
